### rtl/hbfr_pkg.sv
// Shared types and constants for the HVAC bus frame receiver.
package hbfr_pkg;

    localparam logic [7:0] START_MARK = 8'hAA;
    localparam logic [7:0] END_MARK   = 8'h55;
    localparam logic [7:0] CHECK_BASE = 8'hFF;

    localparam logic [7:0] TYPE_STATUS_A = 8'hC0;
    localparam logic [7:0] TYPE_STATUS_B = 8'hC3;
    localparam logic [7:0] TYPE_CMD_A    = 8'hC4;
    localparam logic [7:0] TYPE_CMD_B    = 8'hC6;

    localparam logic [8:0] TEMP_OFFSET = 9'd40;

    localparam int LEN_W = 6;
    localparam logic [LEN_W-1:0] SHORT_FRAME_BYTES = 6'd16;
    localparam logic [LEN_W-1:0] LONG_FRAME_BYTES  = 6'd32;

    // Byte positions captured while a frame is written
    localparam logic [LEN_W-1:0] POS_TYPE   = 6'd1;
    localparam logic [LEN_W-1:0] POS_W_MODE = 6'd6;
    localparam logic [LEN_W-1:0] POS_W_FAN  = 6'd7;
    localparam logic [LEN_W-1:0] POS_S_MODE = 6'd8;
    localparam logic [LEN_W-1:0] POS_S_FAN  = 6'd9;
    localparam logic [LEN_W-1:0] POS_S_SET  = 6'd10;
    localparam logic [LEN_W-1:0] POS_T_IN   = 6'd11;
    localparam logic [LEN_W-1:0] POS_T_COIL = 6'd12;
    localparam logic [LEN_W-1:0] POS_T_OUT  = 6'd14;
    localparam logic [LEN_W-1:0] POS_C_MODE = 6'd16;
    localparam logic [LEN_W-1:0] POS_C_FAN  = 6'd17;
    localparam logic [LEN_W-1:0] POS_C_SET  = 6'd18;
    localparam logic [LEN_W-1:0] POS_FLAGS  = 6'd19;

    typedef enum logic [1:0] {
        KIND_ACCEPT = 2'd0,
        KIND_FAIL   = 2'd1,
        KIND_DROP   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        LAYOUT_NONE    = 2'd0,
        LAYOUT_STATUS  = 2'd1,
        LAYOUT_COMMAND = 2'd2,
        LAYOUT_WAKE    = 2'd3
    } layout_t;

    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_TICK = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BYTE,
        ST_TICK,
        ST_READ,
        ST_EVAL,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic             en;
        logic [LEN_W-1:0] idx;
        logic [7:0]       data;
    } cap_wr_t;

    typedef struct packed {
        kind_t            kind;
        logic [LEN_W-1:0] len;
    } emit_req_t;

    typedef struct packed {
        kind_t             result_kind;
        logic [LEN_W-1:0]  frame_length;
        logic [7:0]        frame_type;
        layout_t           layout;
        logic [7:0]        op_mode;
        logic [7:0]        fan_ctrl;
        logic [7:0]        setpoint;
        logic signed [8:0] temp_indoor;
        logic signed [8:0] temp_coil;
        logic signed [8:0] temp_outdoor;
        logic [7:0]        flags_byte;
    } result_t;

endpackage

### rtl/hbfr_buffer.sv
// Frame buffer memory: one write port, two registered read ports, byte plus running sum.
module hbfr_buffer #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [15:0]   wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr_a,
    input  logic [AW-1:0] raddr_b,
    output logic [15:0]   rdata_a,
    output logic [15:0]   rdata_b
);

    logic [15:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

### rtl/hbfr_decode.sv
// Header byte capture and result field formatting by frame layout.
module hbfr_decode (
    input  logic                clk,
    input  hbfr_pkg::cap_wr_t   cap_wr,
    input  hbfr_pkg::emit_req_t req,
    output hbfr_pkg::result_t   result
);

    logic [7:0] type_reg;
    logic [7:0] w_mode_reg, w_fan_reg;
    logic [7:0] s_mode_reg, s_fan_reg, s_set_reg;
    logic [7:0] t_in_reg, t_coil_reg, t_out_reg;
    logic [7:0] c_mode_reg, c_fan_reg, c_set_reg;
    logic [7:0] flags_reg;

    always_ff @(posedge clk)
    begin
        if (cap_wr.en)
        begin
            case (cap_wr.idx)
                hbfr_pkg::POS_TYPE:   type_reg   <= cap_wr.data;
                hbfr_pkg::POS_W_MODE: w_mode_reg <= cap_wr.data;
                hbfr_pkg::POS_W_FAN:  w_fan_reg  <= cap_wr.data;
                hbfr_pkg::POS_S_MODE: s_mode_reg <= cap_wr.data;
                hbfr_pkg::POS_S_FAN:  s_fan_reg  <= cap_wr.data;
                hbfr_pkg::POS_S_SET:  s_set_reg  <= cap_wr.data;
                hbfr_pkg::POS_T_IN:   t_in_reg   <= cap_wr.data;
                hbfr_pkg::POS_T_COIL: t_coil_reg <= cap_wr.data;
                hbfr_pkg::POS_T_OUT:  t_out_reg  <= cap_wr.data;
                hbfr_pkg::POS_C_MODE: c_mode_reg <= cap_wr.data;
                hbfr_pkg::POS_C_FAN:  c_fan_reg  <= cap_wr.data;
                hbfr_pkg::POS_C_SET:  c_set_reg  <= cap_wr.data;
                hbfr_pkg::POS_FLAGS:  flags_reg  <= cap_wr.data;
                default:
                begin
                end
            endcase
        end
    end

    logic [7:0] frame_type;
    logic       is_accept;
    logic       is_long;
    logic       is_short;

    always_comb
    begin
        frame_type = (req.len >= 6'd2) ? type_reg : 8'h00;
        is_accept  = (req.kind == hbfr_pkg::KIND_ACCEPT);
        is_long    = (req.len == hbfr_pkg::LONG_FRAME_BYTES);
        is_short   = (req.len == hbfr_pkg::SHORT_FRAME_BYTES);

        result               = '0;
        result.result_kind   = req.kind;
        result.frame_length  = req.len;
        result.frame_type    = frame_type;
        result.layout        = hbfr_pkg::LAYOUT_NONE;

        if (is_accept && is_long && (frame_type == hbfr_pkg::TYPE_STATUS_A ||
                                     frame_type == hbfr_pkg::TYPE_STATUS_B))
        begin
            result.layout        = hbfr_pkg::LAYOUT_STATUS;
            result.op_mode       = s_mode_reg;
            result.fan_ctrl      = s_fan_reg;
            result.setpoint      = s_set_reg;
            result.temp_indoor   = $signed({1'b0, t_in_reg} - hbfr_pkg::TEMP_OFFSET);
            result.temp_coil     = $signed({1'b0, t_coil_reg} - hbfr_pkg::TEMP_OFFSET);
            result.temp_outdoor  = $signed({1'b0, t_out_reg} - hbfr_pkg::TEMP_OFFSET);
            result.flags_byte    = flags_reg;
        end
        else if (is_accept && is_long && (frame_type == hbfr_pkg::TYPE_CMD_A ||
                                          frame_type == hbfr_pkg::TYPE_CMD_B))
        begin
            result.layout        = hbfr_pkg::LAYOUT_COMMAND;
            result.op_mode       = c_mode_reg;
            result.fan_ctrl      = c_fan_reg;
            result.setpoint      = c_set_reg;
        end
        else if (is_accept && is_short && frame_type == hbfr_pkg::TYPE_STATUS_B)
        begin
            result.layout        = hbfr_pkg::LAYOUT_WAKE;
            result.op_mode       = w_mode_reg;
            result.fan_ctrl      = w_fan_reg;
            result.setpoint      = s_mode_reg;
        end
    end

endmodule

### rtl/hvac_bus_frame_receiver.sv
// Top level of the HVAC bus frame receiver: control sequencer, buffer and result register.
// Each transfer on the input carries a line byte or a millisecond tick. A byte is handled in
// ST_BYTE, then goes on to ST_EMIT when it completes a 32-byte frame or a closed 16-byte
// frame; a tick is handled in ST_TICK, then goes on to ST_EMIT when at the idle timeout it
// drops a partial frame shorter than SMALLEST_SALVAGE_BYTES. When a tick hits the idle
// timeout with a longer partial frame, the salvage walk tests one candidate length at a time
// (ST_READ reads two buffer entries, then ST_EVAL compares), from the fill level down to
// SMALLEST_SALVAGE_BYTES, at most 28 lengths with the default parameters. Any result also
// waits until the output register is free. The buffer keeps a running byte sum beside each
// byte so each length needs only two reads. A finished result waits in the output register
// while the next transfer is taken in.
module hvac_bus_frame_receiver #(
    parameter int BUFFER_BYTES           = 32,
    parameter int SMALLEST_SALVAGE_BYTES = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // byte_value
    input  logic        s_tuser,    // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,    // frame_length, frame_type, layout, op_mode, fan_ctrl,
                                    // setpoint, temp_indoor, temp_coil, temp_outdoor,
                                    // flags_byte, zero pad
    output logic [1:0]  m_tuser,    // result_kind
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);

    localparam int AW = $clog2(BUFFER_BYTES);
    localparam int FW = $clog2(BUFFER_BYTES + 1);
    localparam logic [FW-1:0] FULL_C    = FW'(BUFFER_BYTES);
    localparam logic [FW-1:0] MIN_LEN_C = FW'(SMALLEST_SALVAGE_BYTES);
    localparam logic [FW-1:0] SHORT_C   = FW'(16);
    localparam logic [FW-1:0] LONG_C    = FW'(32);

    hbfr_pkg::state_t    state_reg, state_next;
    logic [7:0]          byte_reg, byte_next;
    logic [FW-1:0]       fill_reg, fill_next;
    logic [7:0]          sum_reg, sum_next;
    logic [7:0]          prev_reg, prev_next;
    logic [15:0]         idle_reg, idle_next;
    logic [15:0]         timeout_reg;
    logic [FW-1:0]       len_reg, len_next;
    hbfr_pkg::emit_req_t req_reg, req_next;

    logic                out_valid_reg, out_valid_next;
    hbfr_pkg::result_t   out_reg;
    logic                out_free;
    logic                out_load;

    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [15:0]         mem_wdata;
    logic                mem_re;
    logic [AW-1:0]       mem_raddr_a, mem_raddr_b;
    logic [15:0]         mem_rdata_a, mem_rdata_b;

    hbfr_pkg::cap_wr_t   cap_wr;
    hbfr_pkg::result_t   result;

    logic                full;
    logic                start_ok;
    logic [FW-1:0]       eff_fill;
    logic [FW-1:0]       new_fill;
    logic [7:0]          sum_eff;
    logic                close_now;
    logic [7:0]          a_byte, a_cum, b_byte;
    logic                hit;

    hbfr_buffer #(
        .DEPTH (BUFFER_BYTES),
        .AW    (AW)
    ) u_buffer (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .re      (mem_re),
        .raddr_a (mem_raddr_a),
        .raddr_b (mem_raddr_b),
        .rdata_a (mem_rdata_a),
        .rdata_b (mem_rdata_b)
    );

    hbfr_decode u_decode (
        .clk    (clk),
        .cap_wr (cap_wr),
        .req    (req_reg),
        .result (result)
    );

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == hbfr_pkg::ST_IDLE);

    // byte path; the check sum covers the trailer but not the check byte
    always_comb
    begin
        full      = (fill_reg >= FULL_C);
        eff_fill  = full ? '0 : fill_reg;
        start_ok  = (eff_fill == '0) ? (byte_reg == hbfr_pkg::START_MARK) : 1'b1;
        new_fill  = eff_fill + FW'(1);
        sum_eff   = (eff_fill == '0) ? 8'h00 : sum_reg;
        close_now = (byte_reg == hbfr_pkg::END_MARK) &&
                    (prev_reg == hbfr_pkg::CHECK_BASE - (sum_eff + byte_reg - prev_reg));
    end

    // salvage compare
    always_comb
    begin
        a_byte = mem_rdata_a[15:8];
        a_cum  = mem_rdata_a[7:0];
        b_byte = mem_rdata_b[15:8];
        hit    = (a_byte == hbfr_pkg::END_MARK) &&
                 (b_byte == hbfr_pkg::CHECK_BASE - (a_cum - b_byte));
    end

    always_comb
    begin
        state_next  = state_reg;
        byte_next   = byte_reg;
        fill_next   = fill_reg;
        sum_next    = sum_reg;
        prev_next   = prev_reg;
        idle_next   = idle_reg;
        len_next    = len_reg;
        req_next    = req_reg;
        out_load    = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = eff_fill[AW-1:0];
        mem_wdata   = {byte_reg, sum_eff + byte_reg};
        mem_re      = 1'b0;
        mem_raddr_a = AW'(len_reg - FW'(1));
        mem_raddr_b = AW'(len_reg - FW'(2));
        cap_wr.en   = 1'b0;
        cap_wr.idx  = hbfr_pkg::LEN_W'(eff_fill);
        cap_wr.data = byte_reg;

        case (state_reg)
            hbfr_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    byte_next  = s_tdata;
                    state_next = (s_tuser == hbfr_pkg::OP_TICK) ? hbfr_pkg::ST_TICK
                                                                : hbfr_pkg::ST_BYTE;
                end
            end

            hbfr_pkg::ST_BYTE:
            begin
                idle_next  = '0;
                state_next = hbfr_pkg::ST_IDLE;
                if (!start_ok)
                begin
                    fill_next = '0;
                end
                else
                begin
                    mem_we    = 1'b1;
                    cap_wr.en = 1'b1;
                    sum_next  = sum_eff + byte_reg;
                    prev_next = byte_reg;
                    fill_next = new_fill;
                    if (new_fill == SHORT_C && close_now)
                    begin
                        req_next.kind = hbfr_pkg::KIND_ACCEPT;
                        req_next.len  = hbfr_pkg::SHORT_FRAME_BYTES;
                        state_next    = hbfr_pkg::ST_EMIT;
                    end
                    else if (new_fill == LONG_C)
                    begin
                        req_next.kind = close_now ? hbfr_pkg::KIND_ACCEPT
                                                  : hbfr_pkg::KIND_FAIL;
                        req_next.len  = hbfr_pkg::LONG_FRAME_BYTES;
                        state_next    = hbfr_pkg::ST_EMIT;
                    end
                end
            end

            hbfr_pkg::ST_TICK:
            begin
                state_next = hbfr_pkg::ST_IDLE;
                if (fill_reg != '0)
                begin
                    if (idle_reg < timeout_reg)
                    begin
                        idle_next = idle_reg + 16'd1;
                    end
                    else if (fill_reg < MIN_LEN_C)
                    begin
                        req_next.kind = hbfr_pkg::KIND_DROP;
                        req_next.len  = hbfr_pkg::LEN_W'(fill_reg);
                        state_next    = hbfr_pkg::ST_EMIT;
                    end
                    else
                    begin
                        len_next   = fill_reg;
                        state_next = hbfr_pkg::ST_READ;
                    end
                end
            end

            hbfr_pkg::ST_READ:
            begin
                mem_re     = 1'b1;
                state_next = hbfr_pkg::ST_EVAL;
            end

            hbfr_pkg::ST_EVAL:
            begin
                if (hit)
                begin
                    req_next.kind = hbfr_pkg::KIND_ACCEPT;
                    req_next.len  = hbfr_pkg::LEN_W'(len_reg);
                    state_next    = hbfr_pkg::ST_EMIT;
                end
                else if ((len_reg - FW'(1)) < MIN_LEN_C)
                begin
                    req_next.kind = hbfr_pkg::KIND_DROP;
                    req_next.len  = hbfr_pkg::LEN_W'(fill_reg);
                    state_next    = hbfr_pkg::ST_EMIT;
                end
                else
                begin
                    len_next   = len_reg - FW'(1);
                    state_next = hbfr_pkg::ST_READ;
                end
            end

            hbfr_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    fill_next  = '0;
                    idle_next  = '0;
                    state_next = hbfr_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = hbfr_pkg::ST_IDLE;
            end
        endcase

        out_valid_next = out_load || (out_valid_reg && !m_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hbfr_pkg::ST_IDLE;
            fill_reg      <= '0;
            idle_reg      <= '0;
            timeout_reg   <= 16'd20;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            idle_reg      <= idle_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                timeout_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        sum_reg  <= sum_next;
        prev_reg <= prev_next;
        len_reg  <= len_next;
        req_reg  <= req_next;
        if (out_load)
        begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.result_kind;
    assign m_tdata  = {5'd0,
                       out_reg.flags_byte,
                       out_reg.temp_outdoor,
                       out_reg.temp_coil,
                       out_reg.temp_indoor,
                       out_reg.setpoint,
                       out_reg.fan_ctrl,
                       out_reg.op_mode,
                       out_reg.layout,
                       out_reg.frame_type,
                       out_reg.frame_length};

endmodule
